@@ rtl/core/spsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsc_pkg
// Types and constants shared by the sensor to DAC span scaler.
// ----------------------------------------------------------------------------
package spsc_pkg;

  localparam int unsigned DAC_MAX_COUNT   = 4095;
  localparam int unsigned VALUE_FRAC_BITS = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL       = 3'd6;

  localparam logic [1:0] ERR_NONE          = 2'd0;
  localparam logic [1:0] ERR_OVERLOAD      = 2'd1;
  localparam logic [1:0] CLASS_DISPLAYABLE = 2'd1;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_FULL  = 2'd1,
    KIND_SCALE = 2'd2
  } spsc_kind_e;

  typedef struct packed {
    logic signed [31:0] sensor_value;
    logic [1:0]         sensor_class;
    logic [1:0]         error_class;
  } spsc_in_t;

  typedef struct packed {
    logic [11:0] dac_count;
    logic        write_dac;
  } spsc_out_t;

endpackage

@@ rtl/core/sensor_to_dac_span_scaler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_to_dac_span_scaler_core
// Two-point linear scaling of a sensor value to a clamped DAC count.
// ----------------------------------------------------------------------------
// Usage:
// - input channel in_valid_i/in_ready_o/in_data_i carries one sensor sample
//   per transfer; output channel out_valid_o/out_ready_i/out_data_o returns
//   exactly one result per sample, in order
// - configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while no
//   sample is in flight; indexes beyond the register list are ignored
// - a sample passes 21 register stages from input transfer to output valid:
//   input stage, multiply, sign fix-up, 17 restoring divide steps (one
//   quotient bit each) and the output register
// - one sample per cycle unless the receiver stalls; divide chain fully pipelined
// - when the receiver stalls every stage holds; in_ready_o stays high while
//   the output register is empty or being taken, so nothing is lost
// - reset clears all valid bits and loads the register reset values
// ----------------------------------------------------------------------------
module sensor_to_dac_span_scaler_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [spsc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [spsc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  spsc_pkg::spsc_in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output spsc_pkg::spsc_out_t                   out_data_o
);
  import spsc_pkg::*;

  localparam int unsigned QW    = 17;          // quotient bits, top one flags saturation
  localparam int unsigned DW    = 33;          // divisor width
  localparam int unsigned PW    = 45;          // product width
  localparam int unsigned AW    = 46;          // dividend width
  localparam int unsigned CW    = DW + QW;     // compare width
  localparam int unsigned DEPTH = QW + 1;

  localparam logic signed [DW-1:0] VSPAN_ONE = DW'(1) << VALUE_FRAC_BITS;
  localparam logic [DW-1:0] VSPAN_DEF = DW'(DAC_MAX_COUNT) << VALUE_FRAC_BITS;
  localparam logic [16:0]   DAC_MAX_W = 17'(DAC_MAX_COUNT);

  // configuration registers
  logic signed [31:0] vmin_q, vmax_q;
  logic [11:0]        cmin_q, cmax_q;
  logic               enabled_q, manual_q, cal_q;
  logic [DW-1:0]      dspan_q;
  logic [11:0]        cspan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmin_q    <= '0;
      vmax_q    <= '0;
      cmin_q    <= '0;
      cmax_q    <= 12'hfff;
      enabled_q <= 1'b0;
      manual_q  <= 1'b0;
      cal_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VALUE_MIN: vmin_q    <= cfg_data_i;
        CFG_VALUE_MAX: vmax_q    <= cfg_data_i;
        CFG_COUNT_MIN: cmin_q    <= cfg_data_i[11:0];
        CFG_COUNT_MAX: cmax_q    <= cfg_data_i[11:0];
        CFG_ENABLED:   enabled_q <= cfg_data_i[0];
        CFG_MANUAL:    manual_q  <= cfg_data_i[0];
        CFG_CAL:       cal_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // spans derived from the registers and registered
  logic signed [DW-1:0] vspan_w;
  logic signed [12:0]   cdiff_w;
  logic [12:0]          cabs_w;
  logic [DW-1:0]        dspan_d;
  logic [11:0]          cspan_d;

  always_comb begin
    vspan_w = {vmax_q[31], vmax_q} - {vmin_q[31], vmin_q};
    dspan_d = (vspan_w < VSPAN_ONE) ? VSPAN_DEF : vspan_w;
    cdiff_w = $signed({1'b0, cmax_q}) - $signed({1'b0, cmin_q});
    cabs_w  = cdiff_w[12] ? 13'(-cdiff_w) : cdiff_w;
    cspan_d = (17'(cabs_w) > DAC_MAX_W) ? DAC_MAX_W[11:0] : cabs_w[11:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dspan_q <= VSPAN_DEF;
      cspan_q <= 12'hfff;
    end else begin
      dspan_q <= dspan_d;
      cspan_q <= cspan_d;
    end
  end

  logic en;
  logic out_valid_q;
  spsc_out_t out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // input stage, special cases are settled here
  logic               s0_vld_q;
  logic signed [31:0] s0_val_q;
  spsc_kind_e         s0_kind_q, s0_kind_d;
  logic               s0_wr_q;

  always_comb begin
    if (manual_q || cal_q || !enabled_q) begin
      s0_kind_d = KIND_ZERO;
    end else if (in_data_i.error_class == ERR_OVERLOAD) begin
      s0_kind_d = KIND_FULL;
    end else if (in_data_i.error_class == ERR_NONE &&
                 in_data_i.sensor_class == CLASS_DISPLAYABLE) begin
      s0_kind_d = KIND_SCALE;
    end else begin
      s0_kind_d = KIND_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_val_q  <= in_data_i.sensor_value;
      s0_kind_q <= s0_kind_d;
      s0_wr_q   <= !manual_q && !cal_q;
    end
  end

  // multiply stage
  logic                 s1_vld_q;
  logic signed [PW-1:0] s1_prod_q;
  spsc_kind_e           s1_kind_q;
  logic                 s1_wr_q;
  logic signed [DW-1:0] diff_w;
  logic signed [DW+12:0] prod_w;

  assign diff_w = {s0_val_q[31], s0_val_q} - {vmin_q[31], vmin_q};
  assign prod_w = diff_w * $signed({1'b0, cspan_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q <= prod_w[PW-1:0];
      s1_kind_q <= s0_kind_q;
      s1_wr_q   <= s0_wr_q;
    end
  end

  // sign fix-up: a negative dividend is rounded towards minus infinity
  logic [AW-1:0] mag_w, dvd_w;
  logic          neg_w;

  always_comb begin
    neg_w = s1_prod_q[PW-1];
    mag_w = neg_w ? AW'(-s1_prod_q) : AW'(s1_prod_q);
    dvd_w = neg_w ? (mag_w + AW'(dspan_q) - AW'(1)) : mag_w;
  end

  // divide chain, one quotient bit per stage from the top
  logic            dv_vld_q  [DEPTH];
  logic [CW-1:0]   dv_rem_q  [DEPTH];
  logic [QW-1:0]   dv_quo_q  [DEPTH];
  logic            dv_neg_q  [DEPTH];
  spsc_kind_e      dv_kind_q [DEPTH];
  logic            dv_wr_q   [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q[0]  <= CW'(dvd_w);
      dv_quo_q[0]  <= '0;
      dv_neg_q[0]  <= neg_w;
      dv_kind_q[0] <= s1_kind_q;
      dv_wr_q[0]   <= s1_wr_q;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [CW-1:0] dsh_w;
    logic          ge_w;

    assign dsh_w = CW'(dspan_q) << (QW - 1 - j);
    assign ge_w  = dv_rem_q[j] >= dsh_w;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[j+1]  <= ge_w ? (dv_rem_q[j] - dsh_w) : dv_rem_q[j];
        dv_quo_q[j+1]  <= dv_quo_q[j] | (QW'(ge_w) << (QW - 1 - j));
        dv_neg_q[j+1]  <= dv_neg_q[j];
        dv_kind_q[j+1] <= dv_kind_q[j];
        dv_wr_q[j+1]   <= dv_wr_q[j];
      end
    end
  end

  // offset by count min, clamp and pick the result
  logic [QW-1:0] quo_w;
  logic [16:0]   sum_w;
  logic [15:0]   res_w;
  spsc_out_t     out_d;

  always_comb begin
    quo_w = dv_quo_q[DEPTH-1];
    sum_w = {1'b0, quo_w[15:0]} + 17'(cmin_q);
    if (dv_neg_q[DEPTH-1]) begin
      if (quo_w[QW-1] || quo_w[15:0] > 16'(cmin_q)) begin
        res_w = '0;
      end else begin
        res_w = 16'(cmin_q) - quo_w[15:0];
      end
    end else if (quo_w[QW-1] || sum_w > DAC_MAX_W) begin
      res_w = DAC_MAX_W[15:0];
    end else begin
      res_w = sum_w[15:0];
    end

    out_d.write_dac = dv_wr_q[DEPTH-1];
    case (dv_kind_q[DEPTH-1])
      KIND_FULL:  out_d.dac_count = DAC_MAX_W[11:0];
      KIND_SCALE: out_d.dac_count = res_w[11:0];
      default:    out_d.dac_count = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_vld_q[DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/sv/sensor_to_dac_span_scaler_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_to_dac_span_scaler_core_tb
// Self-checking bench for the span scaler. A short directed set covers the
// field extremes, every sensor and error class and each mode. It is followed
// by random samples under a range of span settings. Each accepted sample is
// scaled by a local integer model, and the expected count is queued and
// compared with every result transfer. Input and output idling vary by phase.
// ----------------------------------------------------------------------------
module sensor_to_dac_span_scaler_core_tb;
  import spsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  spsc_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  spsc_out_t             out_data_o;

  sensor_to_dac_span_scaler_core DUT (.*);

  // local copy of the register file
  logic signed [31:0] span_value_lo;
  logic signed [31:0] span_value_hi;
  logic [11:0]        span_count_lo;
  logic [11:0]        span_count_hi;
  logic               chan_enabled;
  logic               chan_manual;
  logic               chan_cal;

  spsc_in_t  sample_queue[$];
  spsc_out_t expected_counts[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned results_checked;
  int unsigned writes_seen;
  bit          in_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic spsc_out_t scale_to_dac(spsc_in_t s);
    spsc_out_t o;
    longint one;
    longint vspan;
    longint cspan;
    longint num;
    longint q;
    longint r;
    one = longint'(1) << VALUE_FRAC_BITS;
    o.write_dac = !(chan_manual || chan_cal);
    o.dac_count = '0;
    if (o.write_dac && chan_enabled) begin
      if (s.error_class == ERR_OVERLOAD) begin
        o.dac_count = 12'(DAC_MAX_COUNT);
      end else if (s.error_class == ERR_NONE && s.sensor_class == CLASS_DISPLAYABLE) begin
        vspan = longint'(span_value_hi) - longint'(span_value_lo);
        if (vspan < one) vspan = longint'(DAC_MAX_COUNT) * one;
        cspan = longint'(span_count_hi) - longint'(span_count_lo);
        if (cspan < 0) cspan = -cspan;
        if (cspan > DAC_MAX_COUNT) cspan = DAC_MAX_COUNT;
        num = (longint'(s.sensor_value) - longint'(span_value_lo)) * cspan;
        q = num / vspan;
        r = num % vspan;
        if (r != 0 && ((r < 0) != (vspan < 0))) q = q - 1;
        q = q + longint'(span_count_lo);
        if (q < 0) q = 0;
        if (q > DAC_MAX_COUNT) q = DAC_MAX_COUNT;
        o.dac_count = q[11:0];
      end
    end
    return o;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_VALUE_MIN: span_value_lo = data;
      CFG_VALUE_MAX: span_value_hi = data;
      CFG_COUNT_MIN: span_count_lo = data[11:0];
      CFG_COUNT_MAX: span_count_hi = data[11:0];
      CFG_ENABLED:   chan_enabled  = data[0];
      CFG_MANUAL:    chan_manual   = data[0];
      CFG_CAL:       chan_cal      = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_span(input logic [31:0] vlo, input logic [31:0] vhi,
                          input logic [11:0] clo, input logic [11:0] chi);
    write_reg(CFG_VALUE_MIN, vlo);
    write_reg(CFG_VALUE_MAX, vhi);
    write_reg(CFG_COUNT_MIN, {20'h0, clo});
    write_reg(CFG_COUNT_MAX, {20'h0, chi});
  endtask

  task automatic set_modes(input bit en, input bit man, input bit cal);
    write_reg(CFG_ENABLED, {31'h0, en});
    write_reg(CFG_MANUAL, {31'h0, man});
    write_reg(CFG_CAL, {31'h0, cal});
  endtask

  task automatic wait_drained();
    wait (sample_queue.size() == 0 && expected_counts.size() == 0 && !in_valid_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_sample(input logic [31:0] v, input logic [1:0] sc,
                             input logic [1:0] ec);
    spsc_in_t s;
    s.sensor_value = v;
    s.sensor_class = sc;
    s.error_class  = ec;
    sample_queue.push_back(s);
  endtask

  // mostly well-formed displayable samples spread around the configured span
  task automatic push_random(input int unsigned n);
    longint lo;
    longint width;
    longint v;
    int unsigned pick;
    lo = span_value_lo;
    width = longint'(span_value_hi) - lo;
    if (width < 256) width = 4095 * 256;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        push_sample($urandom, 2'($urandom), 2'($urandom));
      end else begin
        v = lo - width / 4 + longint'({$urandom, $urandom} % 64'(width + width / 2 + 1));
        push_sample(v[31:0], (pick < 90) ? CLASS_DISPLAYABLE : 2'($urandom),
                    (pick < 85) ? ERR_NONE : 2'($urandom));
      end
    end
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data_i  <= sample_queue.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    in_taken = 1'b0;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    spsc_out_t exp_o;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_counts.size());
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_counts.push_back(scale_to_dac(in_data_i));
      in_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result count=%0d write=%0b", $time,
                 out_data_o.dac_count, out_data_o.write_dac);
        error_count++;
      end else begin
        exp_o = expected_counts.pop_front();
        results_checked++;
        if (exp_o.write_dac) writes_seen++;
        if (out_data_o.dac_count !== exp_o.dac_count) begin
          $display("%0t: dac_count expected %0d actual %0d", $time,
                   exp_o.dac_count, out_data_o.dac_count);
          error_count++;
        end
        if (out_data_o.write_dac !== exp_o.write_dac) begin
          $display("%0t: write_dac expected %0b actual %0b", $time,
                   exp_o.write_dac, out_data_o.write_dac);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    in_taken = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycle_count = 0;
    error_count = 0;
    results_checked = 0;
    writes_seen = 0;
    span_value_lo = 0;
    span_value_hi = 0;
    span_count_lo = 0;
    span_count_hi = 12'd4095;
    chan_enabled = 1'b0;
    chan_manual = 1'b0;
    chan_cal = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // disabled channel straight out of reset
    push_sample(32'h7fffffff, CLASS_DISPLAYABLE, ERR_NONE);
    push_sample(32'h80000000, CLASS_DISPLAYABLE, ERR_OVERLOAD);
    wait_drained();

    // enabled with reset spans: zero value span falls back to full scale
    write_reg(CFG_ENABLED, 32'h1);
    write_reg(CFG_UNUSED, 32'hffffffff);
    for (int c = 0; c < 4; c++) begin
      for (int e = 0; e < 4; e++) push_sample(32'd1000 * 256, 2'(c), 2'(e));
    end
    push_sample(32'h7fffffff, CLASS_DISPLAYABLE, ERR_NONE);
    push_sample(32'h80000000, CLASS_DISPLAYABLE, ERR_NONE);
    push_sample(32'h0, CLASS_DISPLAYABLE, ERR_NONE);
    wait_drained();

    // manual and calibration modes suppress the write
    write_reg(CFG_MANUAL, 32'h1);
    push_sample(32'd500, CLASS_DISPLAYABLE, ERR_OVERLOAD);
    wait_drained();
    write_reg(CFG_MANUAL, 32'h0);
    write_reg(CFG_CAL, 32'h1);
    push_sample(32'd500, CLASS_DISPLAYABLE, ERR_NONE);
    wait_drained();
    write_reg(CFG_CAL, 32'h0);

    for (int p = 0; p < 10; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      case (p)
        0: set_span(32'h80000000, 32'h7fffffff, 12'd0, 12'd4095);
        1: set_span(32'hffffec00, 32'd25600, 12'd400, 12'd3800);
        2: set_span(32'd51200, 32'd0, 12'd4095, 12'd0);
        3: set_span(32'd0, 32'd255, 12'd100, 12'd200);
        4: set_span(32'd0, 32'd256, 12'd4095, 12'd0);
        5: set_span($urandom, $urandom, 12'($urandom), 12'($urandom));
        6: set_span(32'h7fffff00, 32'h7fffffff, 12'd0, 12'd4095);
        7: set_span(32'd1000, 32'd1000 + $urandom_range(100000, 256),
                    12'($urandom), 12'($urandom));
        8: set_span(32'hffff0000, 32'h00010000, 12'd2000, 12'd2000);
        default: set_span($urandom, $urandom, 12'($urandom), 12'($urandom));
      endcase
      set_modes((p != 5), (p == 7), (p == 9));
      push_random(80);
      if (p == 3) begin
        // sender holds off until the pipeline has fully emptied
        wait_drained();
      end
      push_random(83);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("checked %0d results (%0d DAC writes) over ten span settings", results_checked,
             writes_seen);
    $display("directed classes, errors and modes plus random samples with varied idling");
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/spsc_pkg.sv
rtl/core/sensor_to_dac_span_scaler_core.sv
tb/sv/sensor_to_dac_span_scaler_core_tb.sv
